// File: hdl/omr_pkg.sv
// Shared types and constants for the ordered key/value table with rank.
// No dependencies; every other file imports this package.
package omr_pkg;

   localparam int KEY_W  = 31;
   localparam int VAL_W  = 54;
   localparam int POS_W  = 11;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   typedef logic signed [KEY_W-1:0] omr_key_type;
   typedef logic [VAL_W-1:0]        omr_value_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_RANK   = 2'd3
   } omr_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_ABSENT    = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_FULL      = 2'd3
   } omr_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } omr_state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic sample;   // compare the stored key against the incoming key
      logic ins;      // open a slot at the insert point, shift right
      logic del;      // close the slot at the matching cell, shift left
   } omr_cell_ctrl_type;

   // per-cell compare result, latched on sample
   typedef struct packed {
      logic lt;       // cell occupied and its key below the request key
      logic eq;       // cell occupied and its key equal to the request key
   } omr_cell_flag_type;

endpackage

// File: hdl/omr_req_if.sv
// Request channel: valid/ready handshake carrying command, key and value.
// Depends on omr_pkg.
interface omr_req_if import omr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic signed [KEY_W-1:0] key;
   logic [VAL_W-1:0]    value;

   modport source (output valid, output command, output key, output value, input ready);
   modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// File: hdl/omr_rsp_if.sv
// Response channel: valid/ready handshake carrying found value, position and status.
// Depends on omr_pkg.
interface omr_rsp_if import omr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VAL_W-1:0]    found_value;
   logic [POS_W-1:0]    position;
   logic [STAT_W-1:0]   status;

   modport source (output valid, output found_value, output position, output status,
                   input ready);
   modport sink   (input valid, input found_value, input position, input status,
                   output ready);
endinterface

// File: hdl/omr_cell.sv
// One slot of the sorted row: holds a key/value pair and its compare flags,
// and takes its neighbor's pair when the row shifts. Depends on omr_pkg.
module omr_cell import omr_pkg::*; (
   input  logic              clock,
   input  omr_cell_ctrl_type ctrl,
   input  logic              occupied,
   input  omr_key_type       cmp_key,
   input  omr_key_type       new_key,
   input  omr_value_type     new_value,
   input  logic              left_lt,
   input  omr_key_type       left_key,
   input  omr_value_type     left_value,
   input  omr_key_type       right_key,
   input  omr_value_type     right_value,
   output omr_key_type       key,
   output omr_value_type     value,
   output omr_cell_flag_type flag
);

   omr_key_type       key_ff, key_in;
   omr_value_type     value_ff, value_in;
   omr_cell_flag_type flag_ff, flag_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      flag_in  = flag_ff;
      if (ctrl.sample) begin
         flag_in.lt = occupied && (key_ff < cmp_key);
         flag_in.eq = occupied && (key_ff == cmp_key);
      end
      if (ctrl.ins && !flag_ff.lt) begin
         // first cell not below the key is the insert point
         if (left_lt) begin
            key_in   = new_key;
            value_in = new_value;
         end else begin
            key_in   = left_key;
            value_in = left_value;
         end
      end else if (ctrl.del && !flag_ff.lt) begin
         key_in   = right_key;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      flag_ff  <= flag_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign flag  = flag_ff;

endmodule

// File: hdl/ordered_map_with_rank.sv
// Sorted key/value table with rank, held as a row of CAPACITY cells kept in
// ascending signed key order. Each request goes through IDLE and EXEC: in the
// cycle it is accepted the key is compared against all cells at once and the
// flags are latched; in EXEC the row shifts one place (insert or delete) and
// the response is formed and registered. A new request is taken while the
// previous response still waits; EXEC stalls only when the response register
// is still full. No clearing pass is needed after reset.
// Depends on omr_pkg, omr_req_if, omr_rsp_if and omr_cell.
module ordered_map_with_rank import omr_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic       clock,
   input  logic       reset,
   omr_req_if.sink    req_chan,
   omr_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   omr_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   omr_cmd_type       cmd_ff;
   omr_key_type       key_ff;
   omr_value_type     value_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   omr_value_type     found_ff, found_in;
   logic [POS_W-1:0]  position_ff, position_in;
   omr_status_type    status_ff, status_in;

   logic              accept;
   logic              fire;
   logic              hit;
   logic              full;
   logic [CNT_W-1:0]  pos;
   omr_value_type     hit_value;
   omr_cell_ctrl_type ctrl;

   omr_key_type       cell_key   [CAPACITY];
   omr_value_type     cell_value [CAPACITY];
   omr_cell_flag_type cell_flag  [CAPACITY];

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          occ;
      logic          l_lt;
      omr_key_type   l_key;
      omr_value_type l_value;
      omr_key_type   r_key;
      omr_value_type r_value;

      assign occ = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign l_lt    = 1'b1;
         assign l_key   = key_ff;
         assign l_value = value_ff;
      end else begin : g_mid
         assign l_lt    = cell_flag[i-1].lt;
         assign l_key   = cell_key[i-1];
         assign l_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_key   = cell_key[i];
         assign r_value = cell_value[i];
      end else begin : g_inner
         assign r_key   = cell_key[i+1];
         assign r_value = cell_value[i+1];
      end

      omr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .cmp_key     (req_chan.key),
         .new_key     (key_ff),
         .new_value   (value_ff),
         .left_lt     (l_lt),
         .left_key    (l_key),
         .left_value  (l_value),
         .right_key   (r_key),
         .right_value (r_value),
         .key         (cell_key[i]),
         .value       (cell_value[i]),
         .flag        (cell_flag[i])
      );
   end

   // flags are one-hot at the match and at the lower-bound edge
   always_comb begin
      hit       = 1'b0;
      hit_value = '0;
      pos       = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit       = hit | cell_flag[i].eq;
         hit_value = hit_value | (cell_flag[i].eq ? cell_value[i] : '0);
         if (i == 0) begin
            pos = pos | (!cell_flag[i].lt ? CNT_W'(i) : '0);
         end else begin
            pos = pos | ((!cell_flag[i].lt && cell_flag[i-1].lt) ? CNT_W'(i) : '0);
         end
      end
      if (cell_flag[CAPACITY-1].lt) begin
         pos = CNT_W'(CAPACITY);
      end
   end

   assign full = (count_ff == CNT_W'(CAPACITY));

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_chan.ready = 1'b0;
      fire           = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_EXEC: fire = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign accept      = req_chan.valid && req_chan.ready;
   assign ctrl.sample = accept;
   assign ctrl.ins    = fire && (cmd_ff == CMD_INSERT) && !hit && !full;
   assign ctrl.del    = fire && (cmd_ff == CMD_DELETE) && hit;

   // response
   always_comb begin
      found_in    = '0;
      position_in = '0;
      status_in   = STAT_OK;
      case (cmd_ff)
         CMD_INSERT: begin
            if (hit) begin
               status_in = STAT_DUPLICATE;
            end else if (full) begin
               status_in = STAT_FULL;
            end
         end
         CMD_LOOKUP: begin
            if (hit) begin
               found_in = hit_value;
            end else begin
               status_in = STAT_ABSENT;
            end
         end
         CMD_DELETE: begin
            if (!hit) begin
               status_in = STAT_ABSENT;
            end
         end
         default: position_in = POS_W'(pos);
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= omr_cmd_type'(req_chan.command);
         key_ff   <= req_chan.key;
         value_ff <= req_chan.value;
      end
      if (fire) begin
         found_ff    <= found_in;
         position_ff <= position_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found_value = found_ff;
   assign rsp_chan.position    = position_ff;
   assign rsp_chan.status      = status_ff;

endmodule

// File: test/tb_top.sv
// Self-checking bench for ordered_map_with_rank: directed and random requests with
// random idling on both channels, checked against a sorted-table predictor.
// Depends on omr_pkg, omr_req_if, omr_rsp_if and the RTL of the block.
module tb_top;
   import omr_pkg::*;

   localparam int TABLE_DEPTH      = 1024;
   localparam int KEY_LO           = -999999999;
   localparam int KEY_HI           = 999999999;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int TAIL_CYCLES      = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS      = 10;

   typedef struct {
      omr_cmd_type   cmd;
      omr_key_type   key;
      omr_value_type value;
   } map_request_type;

   typedef struct {
      omr_value_type  found;
      logic [POS_W-1:0] position;
      omr_status_type status;
   } map_answer_type;

   logic clock;
   logic reset;

   omr_req_if req_chan ();
   omr_rsp_if rsp_chan ();

   ordered_map_with_rank #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted contents, ascending by signed key
   omr_key_type   stored_keys[$];
   omr_value_type stored_vals[$];

   map_request_type request_backlog[$];
   map_answer_type  pending_answers[$];
   int              live_keys[$];       // keys the generator believes may be present

   int   total_requests = 0;
   int   requests_taken = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   send_burst     = 0;
   int   recv_stall     = 0;
   int   recv_burst     = 0;
   logic hold_responses;

   function automatic map_answer_type resolve_request(omr_cmd_type cmd, omr_key_type key,
                                                      omr_value_type value);
      map_answer_type ans;
      int lo, hi, mid;
      bit hit;
      ans.found    = '0;
      ans.position = '0;
      ans.status   = STAT_OK;
      lo = 0;
      hi = stored_keys.size();
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (stored_keys[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      hit = (lo < stored_keys.size()) && (stored_keys[lo] == key);
      case (cmd)
         CMD_INSERT: begin
            // duplicate takes precedence over full
            if (hit) ans.status = STAT_DUPLICATE;
            else if (stored_keys.size() >= TABLE_DEPTH) ans.status = STAT_FULL;
            else begin
               stored_keys.insert(lo, key);
               stored_vals.insert(lo, value);
            end
         end
         CMD_LOOKUP: begin
            if (hit) ans.found = stored_vals[lo];
            else ans.status = STAT_ABSENT;
         end
         CMD_DELETE: begin
            if (hit) begin
               stored_keys.delete(lo);
               stored_vals.delete(lo);
            end else begin
               ans.status = STAT_ABSENT;
            end
         end
         default: ans.position = lo[POS_W-1:0];
      endcase
      return ans;
   endfunction

   function automatic void report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, what);
   endfunction

   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return int'($urandom_range(1, 3));
      if (roll < 96) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic int rand_key();
      return int'($urandom_range(0, 1999999998)) - 999999999;
   endfunction

   function automatic omr_value_type rand_value();
      return omr_value_type'({$urandom(), $urandom()});
   endfunction

   function automatic int pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70 && live_keys.size() > 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (roll < 95) return rand_key();
      return (roll[0]) ? KEY_HI : KEY_LO;
   endfunction

   function automatic void add_request(omr_cmd_type cmd, int key, omr_value_type value);
      map_request_type r;
      r.cmd   = cmd;
      r.key   = omr_key_type'(key);
      r.value = value;
      request_backlog.push_back(r);
   endfunction

   // one random request; rank takes whatever the other shares leave
   function automatic void queue_mixed(int ins_pct, int del_pct, int look_pct);
      int roll, idx, k;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
         if (live_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
         end else begin
            k = rand_key();
            live_keys.push_back(k);
         end
         add_request(CMD_INSERT, k, rand_value());
      end else if (roll < ins_pct + del_pct) begin
         if (live_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, live_keys.size() - 1);
            k = live_keys[idx];
            live_keys.delete(idx);
         end else begin
            k = rand_key();
         end
         add_request(CMD_DELETE, k, rand_value());
      end else if (roll < ins_pct + del_pct + look_pct) begin
         add_request(CMD_LOOKUP, pick_key(), rand_value());
      end else begin
         add_request(CMD_RANK, pick_key(), rand_value());
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ordered_map_with_rank verification failed");
         $finish;
      end
   end

   // request side: hold until taken, then optionally idle before the next one
   always @(posedge clock) begin : req_driver
      map_request_type nxt;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.command <= CMD_INSERT;
         req_chan.key     <= '0;
         req_chan.value   <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pending_answers.push_back(resolve_request(omr_cmd_type'(req_chan.command),
                                                      req_chan.key, req_chan.value));
            requests_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               nxt = request_backlog.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.command <= nxt.cmd;
               req_chan.key     <= nxt.key;
               req_chan.value   <= nxt.value;
               if (send_burst > 0) begin
                  send_burst--;
                  send_gap = 0;
               end else begin
                  send_gap = pick_idle();
                  if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(30, 100);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      map_answer_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding: value %h pos %0d st %0d",
                                         rsp_chan.found_value, rsp_chan.position,
                                         rsp_chan.status));
            end else begin
               want = pending_answers.pop_front();
               if (rsp_chan.found_value !== want.found)
                  report_mismatch($sformatf("found_value exp %h got %h",
                                            want.found, rsp_chan.found_value));
               if (rsp_chan.position !== want.position)
                  report_mismatch($sformatf("position exp %0d got %0d",
                                            want.position, rsp_chan.position));
               if (rsp_chan.status !== want.status)
                  report_mismatch($sformatf("status exp %0d got %0d",
                                            want.status, rsp_chan.status));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_responses) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (recv_burst > 0) recv_burst--;
            else if ($urandom_range(0, 99) < 15) recv_stall = pick_idle();
            else if ($urandom_range(0, 99) == 0) recv_burst = $urandom_range(50, 200);
         end
      end
   end

   // one long response stall while requests keep coming, so the block backs up
   initial begin : rsp_long_hold
      hold_responses = 1'b0;
      while (requests_taken < 300) @(posedge clock);
      hold_responses <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      hold_responses <= 1'b0;
   end

   initial begin : main_seq
      reset = 1'b1;

      // empty table, extremes, duplicate, absent keys, rank of a missing key
      add_request(CMD_RANK,   KEY_LO, '0);
      add_request(CMD_LOOKUP, KEY_HI, '0);
      add_request(CMD_DELETE, 0,      '0);
      add_request(CMD_INSERT, KEY_HI, '1);
      add_request(CMD_INSERT, KEY_LO, '0);
      add_request(CMD_INSERT, 0,      {27{2'b10}});
      add_request(CMD_INSERT, -1,     {27{2'b01}});
      add_request(CMD_INSERT, KEY_HI, {27{2'b01}});
      add_request(CMD_LOOKUP, KEY_HI, '0);
      add_request(CMD_LOOKUP, KEY_LO, '1);
      add_request(CMD_LOOKUP, 5,      '0);
      add_request(CMD_RANK,   KEY_HI, '0);
      add_request(CMD_RANK,   KEY_LO, '0);
      add_request(CMD_RANK,   1,      '0);
      add_request(CMD_DELETE, 0,      '0);
      add_request(CMD_DELETE, 0,      '0);
      add_request(CMD_LOOKUP, 0,      '0);
      add_request(CMD_RANK,   KEY_HI, '0);
      add_request(CMD_DELETE, KEY_LO, '0);
      add_request(CMD_DELETE, KEY_HI, '0);
      add_request(CMD_DELETE, -1,     '0);
      add_request(CMD_RANK,   KEY_HI, '0);

      // fill past capacity, churn at full, then drain
      while (live_keys.size() < TABLE_DEPTH + 40) queue_mixed(88, 3, 5);
      add_request(CMD_RANK, KEY_HI, '0);
      add_request(CMD_RANK, KEY_LO, '0);
      repeat (120) queue_mixed(40, 5, 25);
      repeat (250) queue_mixed(10, 60, 15);
      total_requests = request_backlog.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < total_requests || pending_answers.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_answers.size()));

      if (mismatches == 0) $display("ordered_map_with_rank verification clean");
      else $display("ordered_map_with_rank verification failed");
      $finish;
   end

endmodule

// File: ordered_map_with_rank.f
hdl/omr_pkg.sv
hdl/omr_req_if.sv
hdl/omr_rsp_if.sv
hdl/omr_cell.sv
hdl/ordered_map_with_rank.sv
test/tb_top.sv
